// File: hdl/json_byte_tokenizer_core_defines.svh
// Assertion macros shared by the json byte tokenizer RTL.
// Included by the modules that carry concurrent assertions; needs clk_i and rst_ni in scope.
`ifndef JSON_BYTE_TOKENIZER_CORE_DEFINES_SVH
`define JSON_BYTE_TOKENIZER_CORE_DEFINES_SVH

// Checked on every clock edge outside reset.
`define JBT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define JBT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hdl/jbt_pkg.sv
// Types, character constants and small lookup functions of the json byte tokenizer.
// No dependencies; used by the lexer, the result queue and the top level.
package jbt_pkg;

  typedef enum logic [3:0] {
    TOK_END      = 4'd0,
    TOK_LBRACKET = 4'd1,
    TOK_RBRACKET = 4'd2,
    TOK_LBRACE   = 4'd3,
    TOK_RBRACE   = 4'd4,
    TOK_COMMA    = 4'd5,
    TOK_COLON    = 4'd6,
    TOK_STR_BYTE = 4'd7,
    TOK_STR_END  = 4'd8,
    TOK_NUM_BYTE = 4'd9,
    TOK_NUM_END  = 4'd10,
    TOK_NULL     = 4'd11,
    TOK_TRUE     = 4'd12,
    TOK_FALSE    = 4'd13,
    TOK_ERROR    = 4'd14
  } tok_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_EOI_IN_STRING = 3'd1,
    ERR_BAD_KEYWORD   = 3'd2,
    ERR_UNEXPECTED    = 3'd3,
    ERR_NUM_TOO_LONG  = 3'd4
  } err_code_e;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_STR  = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_NUM  = 3'd3,
    MODE_KW   = 3'd4,
    MODE_HALT = 3'd5
  } lex_mode_e;

  typedef enum logic [1:0] {
    KW_NULL  = 2'd0,
    KW_TRUE  = 2'd1,
    KW_FALSE = 2'd2
  } kw_id_e;

  localparam int unsigned KwPosW = 3;

  // Result queue geometry: room for two results from each of two input items.
  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrW  = 2;
  localparam int unsigned ResCntW  = 3;

  localparam logic [7:0] CH_LBRACKET  = "[";
  localparam logic [7:0] CH_RBRACKET  = "]";
  localparam logic [7:0] CH_LBRACE    = "{";
  localparam logic [7:0] CH_RBRACE    = "}";
  localparam logic [7:0] CH_COMMA     = ",";
  localparam logic [7:0] CH_COLON     = ":";
  localparam logic [7:0] CH_QUOTE     = "\"";
  localparam logic [7:0] CH_BACKSLASH = "\\";
  localparam logic [7:0] CH_N         = "n";
  localparam logic [7:0] CH_T         = "t";
  localparam logic [7:0] CH_F         = "f";

  typedef struct packed {
    tok_kind_e  token_kind;
    logic [7:0] text_byte;
    err_code_e  error_code;
    logic       last_of_run;
  } res_t;

  localparam res_t RES_NONE = '{
    token_kind:  TOK_END,
    text_byte:   8'h00,
    error_code:  ERR_NONE,
    last_of_run: 1'b0
  };

  // Up to two results written into the queue in one cycle.
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_num_start(logic [7:0] c);
    return (c >= "0" && c <= "9") || c == ".";
  endfunction

  function automatic logic is_num_char(logic [7:0] c);
    return is_num_start(c) || c == "E" || c == "e" || c == "+" || c == "-";
  endfunction

  function automatic logic [KwPosW-1:0] kw_last(kw_id_e id);
    return (id == KW_FALSE) ? KwPosW'(4) : KwPosW'(3);
  endfunction

  function automatic logic [7:0] kw_letter(kw_id_e id, logic [KwPosW-1:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    case (id)
      KW_TRUE: begin
        case (pos)
          3'd0:    ch = "t";
          3'd1:    ch = "r";
          3'd2:    ch = "u";
          default: ch = "e";
        endcase
      end
      KW_FALSE: begin
        case (pos)
          3'd0:    ch = "f";
          3'd1:    ch = "a";
          3'd2:    ch = "l";
          3'd3:    ch = "s";
          default: ch = "e";
        endcase
      end
      default: begin
        case (pos)
          3'd0:    ch = "n";
          3'd1:    ch = "u";
          default: ch = "l";
        endcase
      end
    endcase
    return ch;
  endfunction

  function automatic tok_kind_e kw_token(kw_id_e id);
    tok_kind_e k;
    case (id)
      KW_TRUE:  k = TOK_TRUE;
      KW_FALSE: k = TOK_FALSE;
      default:  k = TOK_NULL;
    endcase
    return k;
  endfunction

endpackage

// File: hdl/jbt_if.sv
// Valid/ready channel interfaces of the json byte tokenizer: input bytes and result tokens.
// No dependencies.
interface jbt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, in_byte, end_of_input, input ready);
  modport sink (input valid, in_byte, end_of_input, output ready);
endinterface

interface jbt_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] token_kind;
  logic [7:0] text_byte;
  logic [2:0] error_code;
  logic       last_of_run;

  modport source (output valid, token_kind, text_byte, error_code, last_of_run, input ready);
  modport sink (input valid, token_kind, text_byte, error_code, last_of_run, output ready);
endinterface

// File: hdl/jbt_lexer.sv
// Lexer state and next-token logic: one input byte per cycle while fire_i is high, zero to two results out.
// Depends on jbt_pkg and the assertion macros header.
`include "json_byte_tokenizer_core_defines.svh"

module jbt_lexer #(
  parameter int unsigned NUMBER_MAX_CHARS = 63
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  logic [7:0]     in_byte_i,
  input  logic           end_of_input_i,
  output jbt_pkg::push_t push_o
);
  import jbt_pkg::*;

  localparam int unsigned NumLenW = $clog2(NUMBER_MAX_CHARS + 1);

  lex_mode_e           mode_q, mode_d;
  kw_id_e              kw_id_q, kw_id_d;
  logic [KwPosW-1:0]   kw_pos_q, kw_pos_d;
  logic [NumLenW-1:0]  num_len_q, num_len_d;

  // Outcome of the byte as seen from idle mode; also used after a number ends.
  logic                idle_emit;
  res_t                idle_res;
  lex_mode_e           idle_mode;
  logic                idle_kw_set;
  kw_id_e              idle_kw_id;
  logic                idle_num;

  res_t                res0, res1;
  logic [1:0]          res_cnt;
  kw_id_e              kw_sel;
  logic [KwPosW-1:0]   kw_end;
  logic [KwPosW-1:0]   kw_pos_c;

  always_comb begin
    idle_emit   = 1'b0;
    idle_res    = RES_NONE;
    idle_mode   = MODE_IDLE;
    idle_kw_set = 1'b0;
    idle_kw_id  = KW_NULL;
    idle_num    = 1'b0;
    if (end_of_input_i) begin
      idle_emit           = 1'b1;
      idle_res.token_kind = TOK_END;
    end else if (!is_space(in_byte_i)) begin
      case (in_byte_i)
        CH_LBRACKET: begin
          idle_emit           = 1'b1;
          idle_res.token_kind = TOK_LBRACKET;
        end
        CH_RBRACKET: begin
          idle_emit           = 1'b1;
          idle_res.token_kind = TOK_RBRACKET;
        end
        CH_LBRACE: begin
          idle_emit           = 1'b1;
          idle_res.token_kind = TOK_LBRACE;
        end
        CH_RBRACE: begin
          idle_emit           = 1'b1;
          idle_res.token_kind = TOK_RBRACE;
        end
        CH_COMMA: begin
          idle_emit           = 1'b1;
          idle_res.token_kind = TOK_COMMA;
        end
        CH_COLON: begin
          idle_emit           = 1'b1;
          idle_res.token_kind = TOK_COLON;
        end
        CH_QUOTE: idle_mode = MODE_STR;
        CH_N: begin
          idle_mode   = MODE_KW;
          idle_kw_set = 1'b1;
          idle_kw_id  = KW_NULL;
        end
        CH_T: begin
          idle_mode   = MODE_KW;
          idle_kw_set = 1'b1;
          idle_kw_id  = KW_TRUE;
        end
        CH_F: begin
          idle_mode   = MODE_KW;
          idle_kw_set = 1'b1;
          idle_kw_id  = KW_FALSE;
        end
        default: begin
          idle_emit = 1'b1;
          if (is_num_start(in_byte_i)) begin
            idle_res.token_kind = TOK_NUM_BYTE;
            idle_res.text_byte  = in_byte_i;
            idle_mode           = MODE_NUM;
            idle_num            = 1'b1;
          end else begin
            idle_res.token_kind = TOK_ERROR;
            idle_res.error_code = ERR_UNEXPECTED;
            idle_mode           = MODE_HALT;
          end
        end
      endcase
    end
  end

  // A stray keyword id reads as null, and the letter index is clamped to the keyword.
  always_comb begin
    kw_sel   = (kw_id_q == KW_TRUE || kw_id_q == KW_FALSE) ? kw_id_q : KW_NULL;
    kw_end   = kw_last(kw_sel);
    kw_pos_c = (kw_pos_q <= kw_end) ? kw_pos_q : kw_end;
  end

  always_comb begin
    mode_d    = mode_q;
    kw_id_d   = kw_id_q;
    kw_pos_d  = kw_pos_q;
    num_len_d = num_len_q;
    res0      = RES_NONE;
    res1      = RES_NONE;
    res_cnt   = 2'd0;
    case (mode_q)
      MODE_IDLE: begin
        res_cnt = {1'b0, idle_emit};
        res0    = idle_res;
        mode_d  = idle_mode;
        if (idle_kw_set) begin
          kw_id_d  = idle_kw_id;
          kw_pos_d = KwPosW'(1);
        end
        if (idle_num) begin
          num_len_d = NumLenW'(1);
        end
      end
      MODE_STR: begin
        res_cnt = 2'd1;
        if (end_of_input_i) begin
          res0.token_kind = TOK_ERROR;
          res0.error_code = ERR_EOI_IN_STRING;
          mode_d          = MODE_HALT;
        end else if (in_byte_i == CH_QUOTE) begin
          res0.token_kind = TOK_STR_END;
          mode_d          = MODE_IDLE;
        end else begin
          res0.token_kind = TOK_STR_BYTE;
          res0.text_byte  = in_byte_i;
          if (in_byte_i == CH_BACKSLASH) begin
            mode_d = MODE_ESC;
          end
        end
      end
      MODE_ESC: begin
        res_cnt = 2'd1;
        if (end_of_input_i) begin
          res0.token_kind = TOK_ERROR;
          res0.error_code = ERR_EOI_IN_STRING;
          mode_d          = MODE_HALT;
        end else begin
          res0.token_kind = TOK_STR_BYTE;
          res0.text_byte  = in_byte_i;
          mode_d          = MODE_STR;
        end
      end
      MODE_NUM: begin
        if (!end_of_input_i && is_num_char(in_byte_i)) begin
          res_cnt = 2'd1;
          if (num_len_q >= NumLenW'(NUMBER_MAX_CHARS)) begin
            res0.token_kind = TOK_ERROR;
            res0.error_code = ERR_NUM_TOO_LONG;
            mode_d          = MODE_HALT;
          end else begin
            res0.token_kind = TOK_NUM_BYTE;
            res0.text_byte  = in_byte_i;
            num_len_d       = num_len_q + NumLenW'(1);
          end
        end else begin
          // The terminating byte closes the number and is then lexed as fresh input.
          res0.token_kind = TOK_NUM_END;
          res1            = idle_res;
          res_cnt         = idle_emit ? 2'd2 : 2'd1;
          mode_d          = idle_mode;
          num_len_d       = idle_num ? NumLenW'(1) : '0;
          if (idle_kw_set) begin
            kw_id_d  = idle_kw_id;
            kw_pos_d = KwPosW'(1);
          end
        end
      end
      MODE_KW: begin
        if (end_of_input_i || in_byte_i != kw_letter(kw_sel, kw_pos_c)) begin
          res_cnt         = 2'd1;
          res0.token_kind = TOK_ERROR;
          res0.error_code = ERR_BAD_KEYWORD;
          mode_d          = MODE_HALT;
        end else if (kw_pos_c == kw_end) begin
          res_cnt         = 2'd1;
          res0.token_kind = kw_token(kw_sel);
          kw_pos_d        = '0;
          mode_d          = MODE_IDLE;
        end else begin
          kw_pos_d = kw_pos_c + KwPosW'(1);
        end
      end
      default: begin
        mode_d = MODE_HALT;
      end
    endcase
    if (res_cnt == 2'd2) begin
      res1.last_of_run = 1'b1;
    end else begin
      res0.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      kw_id_q   <= KW_NULL;
      kw_pos_q  <= '0;
      num_len_q <= '0;
    end else if (fire_i) begin
      mode_q    <= mode_d;
      kw_id_q   <= kw_id_d;
      kw_pos_q  <= kw_pos_d;
      num_len_q <= num_len_d;
    end
  end

  assign push_o.count  = fire_i ? res_cnt : 2'd0;
  assign push_o.first  = res0;
  assign push_o.second = res1;

  `JBT_ASSERT(a_halt_silent, (mode_q == MODE_HALT) |-> (push_o.count == 2'd0), "halted lexer produced a result")
  `JBT_ASSERT(a_error_halts, (push_o.count == 2'd1 && push_o.first.token_kind == TOK_ERROR) |=> (mode_q == MODE_HALT), "error token did not halt the lexer")

endmodule

// File: hdl/jbt_res_fifo.sv
// Four-entry result queue: takes up to two results a cycle, hands out one a cycle while out_o.ready is high.
// Depends on jbt_pkg, jbt_out_if and the assertion macros header.
`include "json_byte_tokenizer_core_defines.svh"

module jbt_res_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  jbt_pkg::push_t push_i,
  output logic           ready_o,
  jbt_out_if.source      out_o
);
  import jbt_pkg::*;

  res_t               mem_q [ResDepth];
  logic [ResPtrW-1:0] wptr_q, wptr_d;
  logic [ResPtrW-1:0] rptr_q, rptr_d;
  logic [ResCntW-1:0] count_q, count_d;
  logic               pop;
  res_t               head;

  assign pop  = out_o.valid && out_o.ready;
  assign head = mem_q[rptr_q];

  // Input side is open whenever a two-result request would still fit.
  assign ready_o = (count_q <= ResCntW'(ResDepth - 2));

  always_comb begin
    wptr_d  = wptr_q + ResPtrW'(push_i.count);
    rptr_d  = rptr_q + ResPtrW'(pop);
    count_d = count_q + ResCntW'(push_i.count) - ResCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wptr_q + ResPtrW'(1)] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  assign out_o.valid       = (count_q != '0);
  assign out_o.token_kind  = head.token_kind;
  assign out_o.text_byte   = head.text_byte;
  assign out_o.error_code  = head.error_code;
  assign out_o.last_of_run = head.last_of_run;

  `JBT_ASSERT_ALWAYS(a_empty_in_reset, !rst_ni |-> (count_q == '0), "result queue not empty in reset")
  `JBT_ASSERT(a_no_overflow, (push_i.count != 2'd0) |-> (count_q + ResCntW'(push_i.count) <= ResCntW'(ResDepth) + ResCntW'(pop)), "result queue overflow")
  `JBT_ASSERT(a_pop_drains, (pop && push_i.count == 2'd0) |=> (count_q == $past(count_q) - ResCntW'(1)), "pop did not drain an entry")

endmodule

// File: hdl/json_byte_tokenizer_core.sv
// Top level of the json byte tokenizer: lexer plus result queue.
// Depends on jbt_pkg, jbt_in_if, jbt_out_if, jbt_lexer and jbt_res_fifo.

// The tokenizer takes at most one JSON text byte (or end-of-input marker) per clock and
// produces a stream of tokens: punctuation, string and number content one byte per
// token, string and number closers, keywords and a halting error token. A byte is
// taken in one cycle and its results are available from the next; an input byte
// yields zero, one or two results, the second only when a byte both closes a number
// and forms a token itself. Results leave one per cycle through a four-entry queue,
// so input runs at one byte per clock while each byte yields at most one result; the
// output port sets the pace when it stalls or closers double up. After an error token no
// further results appear until reset. NUMBER_MAX_CHARS bounds the length of a number.
module json_byte_tokenizer_core #(
  parameter int unsigned NUMBER_MAX_CHARS = 63
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  jbt_in_if.sink    in_i,
  jbt_out_if.source out_o
);
  import jbt_pkg::*;

  push_t push;
  logic  queue_ready;
  logic  fire;

  assign in_i.ready = queue_ready;
  assign fire       = in_i.valid && queue_ready;

  jbt_lexer #(
    .NUMBER_MAX_CHARS(NUMBER_MAX_CHARS)
  ) u_lexer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .in_byte_i      (in_i.in_byte),
    .end_of_input_i (in_i.end_of_input),
    .push_o         (push)
  );

  jbt_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (queue_ready),
    .out_o   (out_o)
  );

endmodule

// File: bench/json_byte_tokenizer_core_tb.sv
// Self-checking testbench of json_byte_tokenizer_core: JSON text bytes in, checked tokens out.
// Depends on jbt_pkg and the jbt_in_if / jbt_out_if interfaces of the RTL.
`timescale 1ns / 100ps

module json_byte_tokenizer_core_tb;
  import jbt_pkg::*;

  localparam int unsigned NumMax      = 63;
  localparam int unsigned TextBytes   = 540;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned DrainCycles = 16;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } text_item_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  logic       in_valid = 1'b0;
  logic [7:0] in_byte  = 8'h00;
  logic       in_eoi   = 1'b0;
  logic       out_ready = 1'b0;
  logic       hold_on  = 1'b0;

  jbt_in_if  byte_if ();
  jbt_out_if tok_if ();

  assign byte_if.valid        = in_valid;
  assign byte_if.in_byte      = in_byte;
  assign byte_if.end_of_input = in_eoi;
  assign tok_if.ready         = out_ready;

  json_byte_tokenizer_core #(
    .NUMBER_MAX_CHARS(NumMax)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (byte_if),
    .out_o (tok_if)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Text still to be offered, and tokens the lexer model says must come out.
  text_item_t byte_q[$];
  res_t       token_q[$];

  int n_fail     = 0;
  int n_accepted = 0;
  int n_tokens   = 0;
  string tail_name = "";

  // Lexer model state.
  lex_mode_e lx_mode    = MODE_IDLE;
  kw_id_e    lx_kw      = KW_NULL;
  int        lx_kw_pos  = 0;
  int        lx_num_len = 0;
  int        step_count = 0;

  string kw_word [3] = '{"null", "true", "false"};
  string num_set     = "0123456789.Ee+-";
  string punct_set   = "[]{},:";

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    n_fail++;
  endtask

  function automatic bit number_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || c == "." || c == "E" || c == "e" || c == "+" ||
           c == "-";
  endfunction

  // Bytes that the lexer takes without complaint when it is between tokens.
  function automatic bit idle_legal(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D) || c == CH_LBRACKET ||
           c == CH_RBRACKET || c == CH_LBRACE || c == CH_RBRACE || c == CH_COMMA ||
           c == CH_COLON || c == CH_QUOTE || c == CH_N || c == CH_T || c == CH_F ||
           (c >= "0" && c <= "9") || c == ".";
  endfunction

  task automatic emit_token(input tok_kind_e k, input logic [7:0] b, input err_code_e e);
    res_t r;
    r.token_kind  = k;
    r.text_byte   = b;
    r.error_code  = e;
    r.last_of_run = 1'b0;
    token_q.push_back(r);
    step_count++;
  endtask

  task automatic halt_with(input err_code_e e);
    emit_token(TOK_ERROR, 8'h00, e);
    lx_mode = MODE_HALT;
  endtask

  task automatic lex_idle(input logic [7:0] c, input logic eoi);
    if (eoi) begin
      emit_token(TOK_END, 8'h00, ERR_NONE);
    end else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
      // Whitespace between tokens is dropped.
    end else if (c == CH_LBRACKET) begin
      emit_token(TOK_LBRACKET, 8'h00, ERR_NONE);
    end else if (c == CH_RBRACKET) begin
      emit_token(TOK_RBRACKET, 8'h00, ERR_NONE);
    end else if (c == CH_LBRACE) begin
      emit_token(TOK_LBRACE, 8'h00, ERR_NONE);
    end else if (c == CH_RBRACE) begin
      emit_token(TOK_RBRACE, 8'h00, ERR_NONE);
    end else if (c == CH_COMMA) begin
      emit_token(TOK_COMMA, 8'h00, ERR_NONE);
    end else if (c == CH_COLON) begin
      emit_token(TOK_COLON, 8'h00, ERR_NONE);
    end else if (c == CH_QUOTE) begin
      lx_mode = MODE_STR;
    end else if (c == CH_N || c == CH_T || c == CH_F) begin
      if (c == CH_N) lx_kw = KW_NULL;
      else if (c == CH_T) lx_kw = KW_TRUE;
      else lx_kw = KW_FALSE;
      lx_kw_pos = 1;
      lx_mode   = MODE_KW;
    end else if ((c >= "0" && c <= "9") || c == ".") begin
      emit_token(TOK_NUM_BYTE, c, ERR_NONE);
      lx_num_len = 1;
      lx_mode    = MODE_NUM;
    end else begin
      halt_with(ERR_UNEXPECTED);
    end
  endtask

  // Advances the lexer model by one accepted request and queues the tokens it gives.
  task automatic tokenize_byte(input logic [7:0] c, input logic eoi);
    res_t last;
    step_count = 0;
    case (lx_mode)
      MODE_IDLE: lex_idle(c, eoi);
      MODE_STR: begin
        if (eoi) begin
          halt_with(ERR_EOI_IN_STRING);
        end else if (c == CH_QUOTE) begin
          emit_token(TOK_STR_END, 8'h00, ERR_NONE);
          lx_mode = MODE_IDLE;
        end else begin
          emit_token(TOK_STR_BYTE, c, ERR_NONE);
          if (c == CH_BACKSLASH) lx_mode = MODE_ESC;
        end
      end
      MODE_ESC: begin
        if (eoi) begin
          halt_with(ERR_EOI_IN_STRING);
        end else begin
          emit_token(TOK_STR_BYTE, c, ERR_NONE);
          lx_mode = MODE_STR;
        end
      end
      MODE_NUM: begin
        if (!eoi && number_char(c)) begin
          if (lx_num_len >= NumMax) begin
            halt_with(ERR_NUM_TOO_LONG);
          end else begin
            emit_token(TOK_NUM_BYTE, c, ERR_NONE);
            lx_num_len++;
          end
        end else begin
          // The byte that closes a number is then lexed afresh.
          emit_token(TOK_NUM_END, 8'h00, ERR_NONE);
          lx_num_len = 0;
          lx_mode    = MODE_IDLE;
          lex_idle(c, eoi);
        end
      end
      MODE_KW: begin
        if (eoi || c != kw_word[lx_kw][lx_kw_pos]) begin
          halt_with(ERR_BAD_KEYWORD);
        end else if (lx_kw_pos + 1 >= kw_word[lx_kw].len()) begin
          case (lx_kw)
            KW_TRUE:  emit_token(TOK_TRUE, 8'h00, ERR_NONE);
            KW_FALSE: emit_token(TOK_FALSE, 8'h00, ERR_NONE);
            default:  emit_token(TOK_NULL, 8'h00, ERR_NONE);
          endcase
          lx_kw_pos = 0;
          lx_mode   = MODE_IDLE;
        end else begin
          lx_kw_pos++;
        end
      end
      default: lx_mode = MODE_HALT;
    endcase
    if (step_count > 0) begin
      last = token_q.pop_back();
      last.last_of_run = 1'b1;
      token_q.push_back(last);
    end
  endtask

  task automatic push_ch(input logic [7:0] c);
    text_item_t it;
    it.ch  = c;
    it.eoi = 1'b0;
    byte_q.push_back(it);
  endtask

  task automatic push_eoi();
    text_item_t it;
    it.ch  = 8'($urandom_range(0, 255));
    it.eoi = 1'b1;
    byte_q.push_back(it);
  endtask

  task automatic push_space();
    if ($urandom_range(0, 5) == 0) push_ch(8'h20);
    else push_ch(8'(8'h09 + $urandom_range(0, 4)));
  endtask

  task automatic push_number(input int len);
    if ($urandom_range(0, 10) == 10) push_ch(".");
    else push_ch(8'("0" + $urandom_range(0, 9)));
    for (int i = 1; i < len; i++) push_ch(num_set[$urandom_range(0, 14)]);
  endtask

  // Opening quote and content only; escapes may precede any byte, a quote included.
  task automatic push_string_body(input int len);
    logic [7:0] b;
    push_ch(CH_QUOTE);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b == CH_QUOTE || b == CH_BACKSLASH || $urandom_range(0, 7) == 0) push_ch(CH_BACKSLASH);
      push_ch(b);
    end
  endtask

  task automatic push_keyword(input int id, input int upto);
    for (int i = 0; i < upto; i++) push_ch(kw_word[id][i]);
  endtask

  // Driver: bursts of requests separated by random gaps; no new gap starts while the output is held off.
  int gap_left   = 0;
  int burst_left = 0;
  bit drv_next   = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_byte  <= 8'h00;
      in_eoi   <= 1'b0;
    end else begin
      if (in_valid && byte_if.ready) begin
        tokenize_byte(in_byte, in_eoi);
        byte_q.delete(0);
        n_accepted++;
        if (burst_left > 0) burst_left--;
      end
      if (!(in_valid && !byte_if.ready)) begin
        if (gap_left == 0 && burst_left == 0) begin
          burst_left = $urandom_range(1, 48);
          gap_left   = (hold_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        if (gap_left > 0) begin
          gap_left--;
          drv_next = 1'b0;
        end else begin
          drv_next = (byte_q.size() != 0);
        end
        if (drv_next) begin
          in_byte <= byte_q[0].ch;
          in_eoi  <= byte_q[0].eoi;
        end
        in_valid <= drv_next;
      end
    end
  end

  // Monitor: checks every accepted token and stalls the output on changing patterns.
  int   rdy_mode  = 0;
  int   rdy_left  = 0;
  int   rdy_phase = 0;
  bit   rdy_next  = 1'b0;
  res_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (tok_if.valid && out_ready) begin
        n_tokens++;
        if (token_q.size() == 0) begin
          flag_mismatch($sformatf("token %0d: kind %0d arrived with none expected",
                                  n_tokens, tok_if.token_kind));
        end else begin
          want = token_q.pop_front();
          if (tok_if.token_kind !== want.token_kind)
            flag_mismatch($sformatf("token %0d: kind %0d, expected %0d", n_tokens,
                                    tok_if.token_kind, want.token_kind));
          if (tok_if.text_byte !== want.text_byte)
            flag_mismatch($sformatf("token %0d: text byte %0h, expected %0h", n_tokens,
                                    tok_if.text_byte, want.text_byte));
          if (tok_if.error_code !== want.error_code)
            flag_mismatch($sformatf("token %0d: error code %0d, expected %0d", n_tokens,
                                    tok_if.error_code, want.error_code));
          if (tok_if.last_of_run !== want.last_of_run)
            flag_mismatch($sformatf("token %0d: last flag %0b, expected %0b", n_tokens,
                                    tok_if.last_of_run, want.last_of_run));
        end
      end
      if (rdy_left == 0) begin
        rdy_mode = $urandom_range(0, 3);
        rdy_left = $urandom_range(5, 60);
      end else begin
        rdy_left--;
      end
      rdy_phase++;
      case (rdy_mode)
        0:       rdy_next = 1'b1;
        1:       rdy_next = ($urandom_range(0, 3) != 0);
        2:       rdy_next = ($urandom_range(0, 3) == 0);
        default: rdy_next = (rdy_phase % 3 != 0);
      endcase
      out_ready <= rdy_next && !hold_on;
    end
  end

  // One long hold-off of the output, so that the result queue fills and input stalls.
  initial begin
    while (n_accepted < 250) @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  initial begin
    #200000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int  pick;
    int  id;
    int  cut;
    bit  after_num;
    bit  long_done;
    logic [7:0] b;

    // Reset goes low with a real falling edge, before the first rising clock edge.
    #0.5 rst_ni = 1'b0;

    after_num = 1'b0;
    long_done = 1'b0;

    // Directed text: all whitespace, every punctuation mark, NUL and 0xFF inside a string,
    // an escaped quote, digits 0 and 9 and every other number character, a number closed
    // by a comma and by the end marker, a keyword, and an end marker straight after another.
    push_ch(8'h20); push_ch(8'h09); push_ch(8'h0A); push_ch(8'h0B); push_ch(8'h0C);
    push_ch(8'h0D); push_ch(CH_LBRACE); push_ch(CH_QUOTE); push_ch(8'h00); push_ch(8'hFF);
    push_ch(CH_BACKSLASH); push_ch(CH_QUOTE); push_ch(CH_QUOTE); push_ch(CH_COLON);
    push_ch(CH_LBRACKET);
    push_ch("0"); push_ch("."); push_ch("E"); push_ch("e"); push_ch("+"); push_ch("-");
    push_ch("9"); push_ch(CH_COMMA);
    push_keyword(0, 4);
    push_ch(CH_RBRACKET); push_ch(CH_RBRACE); push_ch("."); push_eoi(); push_eoi();

    // Random well-formed text; a number is never followed directly by another one.
    while (byte_q.size() < TextBytes) begin
      pick = $urandom_range(0, 99);
      if (!long_done && byte_q.size() > 300) begin
        if (after_num) push_space();
        push_number(NumMax);
        long_done = 1'b1;
        after_num = 1'b1;
      end else if (pick < 25) begin
        push_string_body(($urandom_range(0, 9) == 0) ? $urandom_range(11, 40)
                                                     : $urandom_range(0, 10));
        push_ch(CH_QUOTE);
        after_num = 1'b0;
      end else if (pick < 45) begin
        if (after_num) begin
          if ($urandom_range(0, 1) == 0) push_space();
          else push_ch(CH_COMMA);
        end
        push_number(($urandom_range(0, 29) == 0) ? NumMax : $urandom_range(1, 8));
        after_num = 1'b1;
      end else if (pick < 60) begin
        id = $urandom_range(0, 2);
        push_keyword(id, kw_word[id].len());
        after_num = 1'b0;
      end else if (pick < 82) begin
        push_ch(punct_set[$urandom_range(0, 5)]);
        after_num = 1'b0;
      end else if (pick < 93) begin
        push_space();
        after_num = 1'b0;
      end else begin
        push_eoi();
        after_num = 1'b0;
      end
    end

    // The run closes on one error, since only a reset clears the halt.
    push_space();
    case ($urandom_range(0, 4))
      0: begin
        tail_name = "end inside a string";
        push_string_body($urandom_range(0, 6));
        if ($urandom_range(0, 1) == 0) push_ch(CH_BACKSLASH);
        push_eoi();
      end
      1: begin
        tail_name = "bad keyword letter";
        id  = $urandom_range(0, 2);
        cut = $urandom_range(1, kw_word[id].len() - 1);
        push_keyword(id, cut);
        if ($urandom_range(0, 2) == 0) begin
          push_eoi();
        end else begin
          do b = 8'($urandom_range(0, 255)); while (b == kw_word[id][cut]);
          push_ch(b);
        end
      end
      2: begin
        tail_name = "unexpected character";
        if ($urandom_range(0, 3) == 0) b = 8'h00;
        else do b = 8'($urandom_range(0, 255)); while (idle_legal(b));
        push_ch(b);
      end
      3: begin
        tail_name = "number too long";
        push_number(NumMax + 1);
      end
      default: begin
        tail_name = "NUL after a number";
        push_number($urandom_range(1, 5));
        push_ch(8'h00);
      end
    endcase
    // Once halted, nothing more may come out.
    repeat (12) begin
      if ($urandom_range(0, 3) == 0) push_eoi();
      else push_ch(8'($urandom_range(0, 255)));
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_q.size() != 0) @(posedge clk_i);
    while (token_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Lexed %0d text requests into %0d checked tokens, with one long output hold-off;",
             n_accepted, n_tokens);
    $display("the text ended on a %s, followed by ignored bytes.", tail_name);
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/jbt_pkg.sv
hdl/jbt_if.sv
hdl/jbt_lexer.sv
hdl/jbt_res_fifo.sv
hdl/json_byte_tokenizer_core.sv
bench/json_byte_tokenizer_core_tb.sv
